FILE: src/pmpt_pkg.sv
// ---------------------------------------------------------------------------
// Point-in-mesh parity test: shared package
// Sizes, codes, the control bundle and the step table of the shared
// multiply-accumulate unit.
// ---------------------------------------------------------------------------
package pmpt_pkg;

  // Mesh and coordinate sizes.
  localparam int MAX_TRIANGLES = 1024;
  localparam int COORD_BITS    = 24;
  localparam int VERTEX_CAP    = 3 * MAX_TRIANGLES;
  localparam int ADDR_W        = $clog2(VERTEX_CAP);
  localparam int CNT_W         = $clog2(VERTEX_CAP + 1);
  localparam int TRI_W         = $clog2(MAX_TRIANGLES + 1);
  localparam int VERTEX_W      = 3 * COORD_BITS;
  localparam int MARGIN_W      = 23;
  localparam int COUNT_W       = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(50000);
  localparam logic signed [COORD_BITS-1:0] LOWEST_RESET = {1'b0, {(COORD_BITS-1){1'b1}}};

  // Datapath widths of the multiply-accumulate unit.
  localparam int DIFF_W = COORD_BITS + 1;      // coordinate difference
  localparam int OPB_W  = DIFF_W + 1;          // multiplier B operand
  localparam int NORM_W = 2 * DIFF_W + 2;      // plane normal component
  localparam int HALF_W = NORM_W / 2;          // normal split point
  localparam int OPA_W  = HALF_W + 1;          // multiplier A operand
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = NORM_W + OPB_W + 2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIFF,
    S_MUL,
    S_ACC,
    S_PUSH
  } state_t;

  typedef enum logic [4:0] {
    A_DX1, A_DY1, A_DZ1, A_DX2, A_DY2, A_DZ2,
    A_NAL, A_NAH, A_NBL, A_NBH, A_NCL, A_NCH,
    A_EX, A_EY, A_FX1, A_FY1, A_HX, A_HY
  } a_sel_t;

  typedef enum logic [3:0] {
    B_DX1, B_DY1, B_DZ1, B_DX2, B_DY2, B_DZ2,
    B_EX, B_EY, B_EZ, B_EBZ, B_GX, B_GY, B_KX, B_KY
  } b_sel_t;

  typedef enum logic [1:0] {
    INIT_KEEP,
    INIT_ZERO,
    INIT_XY
  } acc_init_t;

  typedef enum logic [3:0] {
    SV_NONE, SV_NA, SV_NB, SV_NC, SV_XY,
    SV_S1, SV_S2, SV_C1, SV_C2, SV_C3
  } save_t;

  typedef struct packed {
    a_sel_t    a;
    b_sel_t    b;
    logic      hi;    // product weighs 2^HALF_W
    logic      neg;   // subtract the product
    acc_init_t init;
    save_t     save;
  } uop_t;

  localparam int STEP_COUNT = 20;
  localparam int STEP_W     = $clog2(STEP_COUNT);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEP_COUNT - 1);

  // Control bundle from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic              cap_en;
    logic [1:0]        cap_idx;
    logic              diff_en;
    logic              mul_en;
    logic              acc_en;
    logic [STEP_W-1:0] step;
  } mac_ctl_t;

  // Step table: normal, plane side of both segment ends, three xy edges.
  function automatic uop_t uop_of(logic [STEP_W-1:0] step);
    uop_t u;
    u = '{a: A_DY1, b: B_DZ2, hi: 1'b0, neg: 1'b0, init: INIT_ZERO, save: SV_NONE};
    case (step)
      5'd0:  u = '{A_DY1, B_DZ2, 1'b0, 1'b0, INIT_ZERO, SV_NONE};
      5'd1:  u = '{A_DY2, B_DZ1, 1'b0, 1'b1, INIT_KEEP, SV_NA};
      5'd2:  u = '{A_DZ1, B_DX2, 1'b0, 1'b0, INIT_ZERO, SV_NONE};
      5'd3:  u = '{A_DZ2, B_DX1, 1'b0, 1'b1, INIT_KEEP, SV_NB};
      5'd4:  u = '{A_DX1, B_DY2, 1'b0, 1'b0, INIT_ZERO, SV_NONE};
      5'd5:  u = '{A_DX2, B_DY1, 1'b0, 1'b1, INIT_KEEP, SV_NC};
      5'd6:  u = '{A_NAL, B_EX,  1'b0, 1'b0, INIT_ZERO, SV_NONE};
      5'd7:  u = '{A_NAH, B_EX,  1'b1, 1'b0, INIT_KEEP, SV_NONE};
      5'd8:  u = '{A_NBL, B_EY,  1'b0, 1'b0, INIT_KEEP, SV_NONE};
      5'd9:  u = '{A_NBH, B_EY,  1'b1, 1'b0, INIT_KEEP, SV_XY};
      5'd10: u = '{A_NCL, B_EZ,  1'b0, 1'b0, INIT_XY,   SV_NONE};
      5'd11: u = '{A_NCH, B_EZ,  1'b1, 1'b0, INIT_KEEP, SV_S1};
      5'd12: u = '{A_NCL, B_EBZ, 1'b0, 1'b0, INIT_XY,   SV_NONE};
      5'd13: u = '{A_NCH, B_EBZ, 1'b1, 1'b0, INIT_KEEP, SV_S2};
      5'd14: u = '{A_EX,  B_DY1, 1'b0, 1'b0, INIT_ZERO, SV_NONE};
      5'd15: u = '{A_EY,  B_DX1, 1'b0, 1'b1, INIT_KEEP, SV_C1};
      5'd16: u = '{A_FX1, B_GY,  1'b0, 1'b0, INIT_ZERO, SV_NONE};
      5'd17: u = '{A_FY1, B_GX,  1'b0, 1'b1, INIT_KEEP, SV_C2};
      5'd18: u = '{A_HX,  B_KY,  1'b0, 1'b0, INIT_ZERO, SV_NONE};
      5'd19: u = '{A_HY,  B_KX,  1'b0, 1'b1, INIT_KEEP, SV_C3};
      default: u = '{A_DY1, B_DZ2, 1'b0, 1'b0, INIT_ZERO, SV_NONE};
    endcase
    return u;
  endfunction

endpackage

FILE: src/pmpt_vertex_ram.sv
// ---------------------------------------------------------------------------
// Point-in-mesh parity test: vertex store
// One write port and one read port with registered read data; one word
// holds x, y and z of a vertex.
// ---------------------------------------------------------------------------
module pmpt_vertex_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [pmpt_pkg::ADDR_W-1:0]   waddr,
  input  logic [pmpt_pkg::VERTEX_W-1:0] wdata,
  input  logic [pmpt_pkg::ADDR_W-1:0]   raddr,
  output logic [pmpt_pkg::VERTEX_W-1:0] rdata
);

  logic [pmpt_pkg::VERTEX_W-1:0] mem [pmpt_pkg::VERTEX_CAP];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/pmpt_mac.sv
// ---------------------------------------------------------------------------
// Point-in-mesh parity test: shared multiply-accumulate unit
// Holds one triangle and its coordinate differences, and runs the step
// table through one signed multiplier and one wide accumulator.
// ---------------------------------------------------------------------------
module pmpt_mac (
  input  logic                                   clk,
  input  pmpt_pkg::mac_ctl_t                     ctl,
  input  logic [pmpt_pkg::VERTEX_W-1:0]          rd_data,
  input  logic signed [pmpt_pkg::COORD_BITS-1:0] px,
  input  logic signed [pmpt_pkg::COORD_BITS-1:0] py,
  input  logic signed [pmpt_pkg::COORD_BITS-1:0] pz,
  input  logic signed [pmpt_pkg::DIFF_W-1:0]     bz,
  output logic                                   hit
);

  localparam int CB = pmpt_pkg::COORD_BITS;
  localparam int DW = pmpt_pkg::DIFF_W;
  localparam int AW = pmpt_pkg::OPA_W;
  localparam int BW = pmpt_pkg::OPB_W;
  localparam int NW = pmpt_pkg::NORM_W;
  localparam int HW = pmpt_pkg::HALF_W;
  localparam int PW = pmpt_pkg::PROD_W;
  localparam int CW = pmpt_pkg::ACC_W;

  logic signed [CB-1:0] vx [3];
  logic signed [CB-1:0] vy [3];
  logic signed [CB-1:0] vz [3];

  logic signed [DW-1:0] dx1, dy1, dz1, dx2, dy2, dz2;
  logic signed [DW-1:0] ex, ey, ez, fx1, fy1, gx, gy, hx, hy, kx, ky;
  logic signed [BW-1:0] ebz;

  logic signed [NW-1:0] na, nb, nc;
  logic signed [CW-1:0] xy, acc, acc_next, base, term;
  logic signed [AW-1:0] a_op;
  logic signed [BW-1:0] b_op;
  logic signed [PW-1:0] prod;
  logic [1:0]           s1, s2, c1, c2, c3, sgn_next;
  pmpt_pkg::uop_t       uop;

  // Capture the three vertices of the current triangle.
  always_ff @(posedge clk) begin
    if (ctl.cap_en) begin
      vx[ctl.cap_idx] <= rd_data[3*CB-1:2*CB];
      vy[ctl.cap_idx] <= rd_data[2*CB-1:CB];
      vz[ctl.cap_idx] <= rd_data[CB-1:0];
    end
  end

  // Coordinate differences, all registered together.
  always_ff @(posedge clk) begin
    if (ctl.diff_en) begin
      dx1 <= DW'(vx[1]) - DW'(vx[0]);
      dy1 <= DW'(vy[1]) - DW'(vy[0]);
      dz1 <= DW'(vz[1]) - DW'(vz[0]);
      dx2 <= DW'(vx[2]) - DW'(vx[0]);
      dy2 <= DW'(vy[2]) - DW'(vy[0]);
      dz2 <= DW'(vz[2]) - DW'(vz[0]);
      ex  <= DW'(px) - DW'(vx[0]);
      ey  <= DW'(py) - DW'(vy[0]);
      ez  <= DW'(pz) - DW'(vz[0]);
      ebz <= BW'(bz) - BW'(vz[0]);
      fx1 <= DW'(px) - DW'(vx[1]);
      fy1 <= DW'(py) - DW'(vy[1]);
      gx  <= DW'(vx[2]) - DW'(vx[1]);
      gy  <= DW'(vy[2]) - DW'(vy[1]);
      hx  <= DW'(px) - DW'(vx[2]);
      hy  <= DW'(py) - DW'(vy[2]);
      kx  <= DW'(vx[0]) - DW'(vx[2]);
      ky  <= DW'(vy[0]) - DW'(vy[2]);
    end
  end

  assign uop = pmpt_pkg::uop_of(ctl.step);

  // Operand A select; normal components enter as low and high halves.
  always_comb begin
    case (uop.a)
      pmpt_pkg::A_DX1: a_op = AW'(dx1);
      pmpt_pkg::A_DY1: a_op = AW'(dy1);
      pmpt_pkg::A_DZ1: a_op = AW'(dz1);
      pmpt_pkg::A_DX2: a_op = AW'(dx2);
      pmpt_pkg::A_DY2: a_op = AW'(dy2);
      pmpt_pkg::A_DZ2: a_op = AW'(dz2);
      pmpt_pkg::A_NAL: a_op = $signed({1'b0, na[HW-1:0]});
      pmpt_pkg::A_NAH: a_op = AW'($signed(na[NW-1:HW]));
      pmpt_pkg::A_NBL: a_op = $signed({1'b0, nb[HW-1:0]});
      pmpt_pkg::A_NBH: a_op = AW'($signed(nb[NW-1:HW]));
      pmpt_pkg::A_NCL: a_op = $signed({1'b0, nc[HW-1:0]});
      pmpt_pkg::A_NCH: a_op = AW'($signed(nc[NW-1:HW]));
      pmpt_pkg::A_EX:  a_op = AW'(ex);
      pmpt_pkg::A_EY:  a_op = AW'(ey);
      pmpt_pkg::A_FX1: a_op = AW'(fx1);
      pmpt_pkg::A_FY1: a_op = AW'(fy1);
      pmpt_pkg::A_HX:  a_op = AW'(hx);
      pmpt_pkg::A_HY:  a_op = AW'(hy);
      default:         a_op = '0;
    endcase
  end

  // Operand B select.
  always_comb begin
    case (uop.b)
      pmpt_pkg::B_DX1: b_op = BW'(dx1);
      pmpt_pkg::B_DY1: b_op = BW'(dy1);
      pmpt_pkg::B_DZ1: b_op = BW'(dz1);
      pmpt_pkg::B_DX2: b_op = BW'(dx2);
      pmpt_pkg::B_DY2: b_op = BW'(dy2);
      pmpt_pkg::B_DZ2: b_op = BW'(dz2);
      pmpt_pkg::B_EX:  b_op = BW'(ex);
      pmpt_pkg::B_EY:  b_op = BW'(ey);
      pmpt_pkg::B_EZ:  b_op = BW'(ez);
      pmpt_pkg::B_EBZ: b_op = ebz;
      pmpt_pkg::B_GX:  b_op = BW'(gx);
      pmpt_pkg::B_GY:  b_op = BW'(gy);
      pmpt_pkg::B_KX:  b_op = BW'(kx);
      pmpt_pkg::B_KY:  b_op = BW'(ky);
      default:         b_op = '0;
    endcase
  end

  // The shared multiplier, registered.
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a_op * b_op;
    end
  end

  // Accumulate the registered product.
  always_comb begin
    case (uop.init)
      pmpt_pkg::INIT_ZERO: base = '0;
      pmpt_pkg::INIT_XY:   base = xy;
      default:             base = acc;
    endcase
    term = uop.hi ? (CW'(prod) <<< HW) : CW'(prod);
    acc_next = uop.neg ? (base - term) : (base + term);
    // Sign code: bit 1 negative, bit 0 positive.
    sgn_next = {acc_next[CW-1], ~acc_next[CW-1] & (acc_next != '0)};
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      acc <= acc_next;
      case (uop.save)
        pmpt_pkg::SV_NA: na <= acc_next[NW-1:0];
        pmpt_pkg::SV_NB: nb <= acc_next[NW-1:0];
        pmpt_pkg::SV_NC: nc <= acc_next[NW-1:0];
        pmpt_pkg::SV_XY: xy <= acc_next;
        pmpt_pkg::SV_S1: s1 <= sgn_next;
        pmpt_pkg::SV_S2: s2 <= sgn_next;
        pmpt_pkg::SV_C1: c1 <= sgn_next;
        pmpt_pkg::SV_C2: c2 <= sgn_next;
        default: ;
      endcase
    end
  end

  // In the final step the edge sign c3 comes straight from the accumulator and decides the crossing.
  assign c3 = sgn_next;
  assign hit = ctl.acc_en && (ctl.step == pmpt_pkg::STEP_LAST)
             && ((s1[1] && s2[0]) || (s1[0] && s2[1]))
             && ((c1[1] && c2[1] && c3[1]) || (c1[0] && c2[0] && c3[0]));

endmodule

FILE: src/point_in_mesh_parity_test_top.sv
// ---------------------------------------------------------------------------
// Point-in-mesh parity test: top level
// Stores a triangle mesh and answers whether a query point lies inside it
// by counting crossings of a vertical segment with the triangles.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one beat per command:
//   clear mesh, load one vertex, or query a point. Loads and clears produce
//   no result. A query produces one result beat on the output channel
//   (out_valid/out_ready): parity, crossing count and the dropped-vertex
//   flag. A query walks every stored triangle: vertex reads from the single
//   read port of the vertex store (one to start the registered read, three
//   to capture), a differences step, then 20 multiply-accumulate steps on
//   the one shared multiplier, each a multiply state and an accumulate
//   state. The input ready signal in_ready stays low while a query runs.
//   Reset empties the mesh, clears the dropped flag and sets ray_margin to
//   its default; the vertex store needs no clearing. If the receiver stalls,
//   the result is held in the output register; loads and clears are still
//   taken, and the next query waits before delivering its own result.
//   The margin register is written through cfg_wr_en/cfg_wr_data.
// ---------------------------------------------------------------------------
module point_in_mesh_parity_test_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [pmpt_pkg::MARGIN_W-1:0]          cfg_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             opcode,
  input  logic signed [pmpt_pkg::COORD_BITS-1:0] coord_x,
  input  logic signed [pmpt_pkg::COORD_BITS-1:0] coord_y,
  input  logic signed [pmpt_pkg::COORD_BITS-1:0] coord_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   inside_res,
  output logic [pmpt_pkg::COUNT_W-1:0]           crossing_count,
  output logic                                   status
);

  localparam int AW = pmpt_pkg::ADDR_W;
  localparam int DW = pmpt_pkg::DIFF_W;

  pmpt_pkg::state_t  state, state_next;
  pmpt_pkg::mac_ctl_t ctl;
  pmpt_pkg::opcode_t op;

  logic [pmpt_pkg::MARGIN_W-1:0]          ray_margin;
  logic [pmpt_pkg::CNT_W-1:0]             vertex_count;
  logic [1:0]                             load_phase;
  logic [pmpt_pkg::TRI_W-1:0]             tri_count, walk_tri;
  logic signed [pmpt_pkg::COORD_BITS-1:0] lowest_z;
  logic                                   overflow_flag;
  logic signed [pmpt_pkg::COORD_BITS-1:0] px, py, pz;
  logic signed [DW-1:0]                   bz;
  logic [AW-1:0]                          base_addr, raddr;
  logic [1:0]                             rd_cnt;
  logic [pmpt_pkg::STEP_W-1:0]            step;
  logic [pmpt_pkg::COUNT_W-1:0]           hit_count;
  logic                                   parity;
  logic                                   hit, accept, store_ok, last_tri;
  logic [pmpt_pkg::VERTEX_W-1:0]          rd_data;

  assign op       = pmpt_pkg::opcode_t'(opcode);
  assign accept   = in_valid && in_ready;
  assign store_ok = vertex_count < pmpt_pkg::CNT_W'(pmpt_pkg::VERTEX_CAP);
  assign last_tri = (walk_tri + 1'b1) == tri_count;
  assign raddr    = base_addr + AW'(rd_cnt);

  // Vertex store.
  pmpt_vertex_ram u_ram (
    .clk   (clk),
    .we    (accept && (op == pmpt_pkg::OP_LOAD) && store_ok),
    .waddr (vertex_count[AW-1:0]),
    .wdata ({coord_x, coord_y, coord_z}),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Shared arithmetic unit.
  pmpt_mac u_mac (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (rd_data),
    .px      (px),
    .py      (py),
    .pz      (pz),
    .bz      (bz),
    .hit     (hit)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pmpt_pkg::S_IDLE: begin
        if (accept && (op == pmpt_pkg::OP_QUERY)) begin
          state_next = (tri_count == '0) ? pmpt_pkg::S_PUSH : pmpt_pkg::S_READ;
        end
      end
      pmpt_pkg::S_READ: begin
        if (rd_cnt == 2'd3) begin
          state_next = pmpt_pkg::S_DIFF;
        end
      end
      pmpt_pkg::S_DIFF: state_next = pmpt_pkg::S_MUL;
      pmpt_pkg::S_MUL:  state_next = pmpt_pkg::S_ACC;
      pmpt_pkg::S_ACC: begin
        if (step == pmpt_pkg::STEP_LAST) begin
          state_next = last_tri ? pmpt_pkg::S_PUSH : pmpt_pkg::S_READ;
        end else begin
          state_next = pmpt_pkg::S_MUL;
        end
      end
      pmpt_pkg::S_PUSH: begin
        if (!out_valid || out_ready) begin
          state_next = pmpt_pkg::S_IDLE;
        end
      end
      default: state_next = pmpt_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready    = 1'b0;
    ctl         = '0;
    ctl.step    = step;
    ctl.cap_idx = rd_cnt - 2'd1;
    unique case (state)
      pmpt_pkg::S_IDLE: in_ready    = 1'b1;
      pmpt_pkg::S_READ: ctl.cap_en  = (rd_cnt != 2'd0);
      pmpt_pkg::S_DIFF: ctl.diff_en = 1'b1;
      pmpt_pkg::S_MUL:  ctl.mul_en  = 1'b1;
      pmpt_pkg::S_ACC:  ctl.acc_en  = 1'b1;
      pmpt_pkg::S_PUSH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmpt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ray_margin <= pmpt_pkg::MARGIN_RESET;
    end else if (cfg_wr_en) begin
      ray_margin <= cfg_wr_data;
    end
  end

  // Mesh bookkeeping: vertex count, triangle count, lowest z, drop flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= '0;
      load_phase    <= '0;
      tri_count     <= '0;
      lowest_z      <= pmpt_pkg::LOWEST_RESET;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      case (op)
        pmpt_pkg::OP_CLEAR: begin
          vertex_count  <= '0;
          load_phase    <= '0;
          tri_count     <= '0;
          lowest_z      <= pmpt_pkg::LOWEST_RESET;
          overflow_flag <= 1'b0;
        end
        pmpt_pkg::OP_LOAD: begin
          if (store_ok) begin
            vertex_count <= vertex_count + 1'b1;
            if (load_phase == 2'd2) begin
              load_phase <= '0;
              tri_count  <= tri_count + 1'b1;
            end else begin
              load_phase <= load_phase + 2'd1;
            end
            if (coord_z < lowest_z) begin
              lowest_z <= coord_z;
            end
          end else begin
            overflow_flag <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Query walk: point, segment bottom, read address, step and hit count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt    <= '0;
      step      <= '0;
      walk_tri  <= '0;
      base_addr <= '0;
      hit_count <= '0;
      parity    <= 1'b0;
    end else begin
      if (accept && (op == pmpt_pkg::OP_QUERY)) begin
        px        <= coord_x;
        py        <= coord_y;
        pz        <= coord_z;
        bz        <= DW'(lowest_z) - $signed(DW'(ray_margin));
        rd_cnt    <= '0;
        step      <= '0;
        walk_tri  <= '0;
        base_addr <= '0;
        hit_count <= '0;
        parity    <= 1'b0;
      end
      if (state == pmpt_pkg::S_READ) begin
        rd_cnt <= (rd_cnt == 2'd3) ? 2'd0 : rd_cnt + 2'd1;
      end
      if (state == pmpt_pkg::S_ACC) begin
        if (step == pmpt_pkg::STEP_LAST) begin
          step      <= '0;
          walk_tri  <= walk_tri + 1'b1;
          base_addr <= base_addr + AW'(3);
          if (hit) begin
            parity <= ~parity;
            if (hit_count != pmpt_pkg::COUNT_MAX) begin
              hit_count <= hit_count + 1'b1;
            end
          end
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  // Output register: one result beat per query.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == pmpt_pkg::S_PUSH) && (!out_valid || out_ready)) begin
      out_valid      <= 1'b1;
      inside_res     <= parity;
      crossing_count <= hit_count;
      status         <= overflow_flag;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // The vertex count always matches the triangle count and load phase.
  a_count_split: assert property (@(posedge clk) disable iff (rst)
    (vertex_count == pmpt_pkg::CNT_W'(3 * tri_count) + pmpt_pkg::CNT_W'(load_phase))
    && (load_phase != 2'd3))
    else $error("vertex count out of step with triangle count");

  // A running walk never steps past the stored triangles.
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    ((state == pmpt_pkg::S_READ) || (state == pmpt_pkg::S_MUL)
     || (state == pmpt_pkg::S_ACC) || (state == pmpt_pkg::S_DIFF))
    |-> (walk_tri < tri_count))
    else $error("triangle walk beyond the mesh");

  // The mesh cannot change while a query runs.
  a_mesh_stable: assert property (@(posedge clk) disable iff (rst)
    (state == pmpt_pkg::S_ACC) |=> $stable(tri_count))
    else $error("mesh changed during a query");
`endif

endmodule

FILE: sim/point_in_mesh_parity_test_top_tb.sv
// ---------------------------------------------------------------------------
// Point-in-mesh parity test: testbench
// Drives clear, load and query beats through the valid/ready input channel,
// predicts every query answer with an exact wide-integer crossing counter,
// and compares each output beat field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module point_in_mesh_parity_test_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [pmpt_pkg::COORD_BITS-1:0] coord_t;

  typedef struct {
    logic                         odd;
    logic [pmpt_pkg::COUNT_W-1:0] count;
    logic                         dropped;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [pmpt_pkg::MARGIN_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = pmpt_pkg::OP_NONE;
  coord_t coord_x = '0;
  coord_t coord_y = '0;
  coord_t coord_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic inside_res;
  logic [pmpt_pkg::COUNT_W-1:0] crossing_count;
  logic status;

  point_in_mesh_parity_test_top uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .inside_res(inside_res), .crossing_count(crossing_count), .status(status)
  );

  always #1 clk = ~clk;

  // Shadow copy of the mesh and the margin register.
  coord_t mesh_x [pmpt_pkg::VERTEX_CAP];
  coord_t mesh_y [pmpt_pkg::VERTEX_CAP];
  coord_t mesh_z [pmpt_pkg::VERTEX_CAP];
  int unsigned mesh_len;
  coord_t mesh_floor;
  logic mesh_dropped;
  logic [pmpt_pkg::MARGIN_W-1:0] margin;

  answer_t pending_answers[$];
  int mismatches = 0;
  bit no_idle = 1'b0;
  int hold_left = 0;

  function automatic int sgn(wide_t v);
    if (v < 0) return -1;
    if (v != 0) return 1;
    return 0;
  endfunction

  // Exact crossing test of the segment (px,py,pz)-(px,py,bz) with one triangle.
  function automatic bit segment_crosses(int unsigned base, wide_t px, wide_t py,
                                         wide_t pz, wide_t bz);
    wide_t x0, y0, z0, x1, y1, z1, x2, y2, z2;
    wide_t na, nb, nc, xy;
    int s1, s2, c1, c2, c3;
    x0 = mesh_x[base];   y0 = mesh_y[base];   z0 = mesh_z[base];
    x1 = mesh_x[base+1]; y1 = mesh_y[base+1]; z1 = mesh_z[base+1];
    x2 = mesh_x[base+2]; y2 = mesh_y[base+2]; z2 = mesh_z[base+2];
    na = (y1 - y0) * (z2 - z0) - (y2 - y0) * (z1 - z0);
    nb = (z1 - z0) * (x2 - x0) - (z2 - z0) * (x1 - x0);
    nc = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
    xy = na * (px - x0) + nb * (py - y0);
    s1 = sgn(xy + nc * (pz - z0));
    s2 = sgn(xy + nc * (bz - z0));
    if (s1 * s2 >= 0) return 1'b0;
    c1 = sgn((px - x0) * (y1 - y0) - (py - y0) * (x1 - x0));
    c2 = sgn((px - x1) * (y2 - y1) - (py - y1) * (x2 - x1));
    c3 = sgn((px - x2) * (y0 - y2) - (py - y2) * (x0 - x2));
    return (c1 < 0 && c2 < 0 && c3 < 0) || (c1 > 0 && c2 > 0 && c3 > 0);
  endfunction

  // Update the shadow mesh for one accepted beat; queue the answer of a query.
  task automatic mesh_apply(pmpt_pkg::opcode_t op, coord_t x, coord_t y, coord_t z);
    answer_t ans;
    wide_t bottom, px, py, pz;
    int unsigned hits;
    case (op)
      pmpt_pkg::OP_CLEAR: begin
        mesh_len = 0;
        mesh_floor = pmpt_pkg::LOWEST_RESET;
        mesh_dropped = 1'b0;
      end
      pmpt_pkg::OP_LOAD: begin
        if (mesh_len >= pmpt_pkg::VERTEX_CAP) begin
          mesh_dropped = 1'b1;
        end else begin
          mesh_x[mesh_len] = x;
          mesh_y[mesh_len] = y;
          mesh_z[mesh_len] = z;
          mesh_len++;
          if (z < mesh_floor) mesh_floor = z;
        end
      end
      pmpt_pkg::OP_QUERY: begin
        bottom = mesh_floor;
        bottom = bottom - wide_t'({1'b0, margin});
        px = x; py = y; pz = z;
        hits = 0;
        for (int unsigned t = 0; t < mesh_len / 3; t++)
          if (segment_crosses(3 * t, px, py, pz, bottom)) hits++;
        ans.odd = hits[0];
        ans.count = (hits > pmpt_pkg::COUNT_MAX) ? pmpt_pkg::COUNT_MAX
                                                 : hits[pmpt_pkg::COUNT_W-1:0];
        ans.dropped = mesh_dropped;
        pending_answers.push_back(ans);
      end
      default: begin
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one beat on the input channel and wait for it to be taken.
  task automatic send_beat(pmpt_pkg::opcode_t op, coord_t x, coord_t y, coord_t z);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode = op;
    coord_x = x;
    coord_y = y;
    coord_z = z;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mesh_apply(op, x, y, z);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait until every predicted answer has arrived, then let loads settle.
  task automatic drain();
    go_quiet();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_margin(logic [pmpt_pkg::MARGIN_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    margin = value;
  endtask

  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return coord_t'($urandom_range(0, 4000)) - coord_t'(2000);
    if (r == 5) begin
      if ($urandom_range(0, 1) == 1) return {1'b0, {(pmpt_pkg::COORD_BITS-1){1'b1}}};
      return {1'b1, {(pmpt_pkg::COORD_BITS-1){1'b0}}};
    end
    return coord_t'($urandom);
  endfunction

  // Receiver: random stalls, plus a counted long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (no_idle) begin
        out_ready = 1'b1;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 99) < 25) stall = pick_gap();
      end
    end
  end

  // Compare each delivered result beat with the oldest prediction.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("result beat with no query waiting");
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (inside_res !== want.odd) begin
          $error("inside_res: expected %0d, got %0d", want.odd, inside_res);
          mismatches++;
        end
        if (crossing_count !== want.count) begin
          $error("crossing_count: expected %0d, got %0d", want.count, crossing_count);
          mismatches++;
        end
        if (status !== want.dropped) begin
          $error("status: expected %0d, got %0d", want.dropped, status);
          mismatches++;
        end
      end
    end
  end

  // Empty mesh, unused opcode and a lone query straight after reset.
  task automatic test_empty_mesh();
    send_beat(pmpt_pkg::OP_QUERY, '0, '0, '0);
    send_beat(pmpt_pkg::OP_NONE, 24'sd5, 24'sd5, 24'sd5);
    send_beat(pmpt_pkg::OP_LOAD, 24'sd10, 24'sd0, 24'sd0);
    send_beat(pmpt_pkg::OP_LOAD, 24'sd0, 24'sd10, 24'sd0);
    send_beat(pmpt_pkg::OP_QUERY, 24'sd1, 24'sd1, 24'sd5);
  endtask

  // Two half-square triangles at different z, a degenerate one, a trailing vertex.
  task automatic test_directed_mesh();
    coord_t hi, lo;
    hi = {1'b0, {(pmpt_pkg::COORD_BITS-1){1'b1}}};
    lo = {1'b1, {(pmpt_pkg::COORD_BITS-1){1'b0}}};
    send_beat(pmpt_pkg::OP_CLEAR, '0, '0, '0);
    send_beat(pmpt_pkg::OP_LOAD, lo, lo, 24'sd0);
    send_beat(pmpt_pkg::OP_LOAD, hi, lo, 24'sd0);
    send_beat(pmpt_pkg::OP_LOAD, hi, hi, 24'sd0);
    send_beat(pmpt_pkg::OP_LOAD, lo, lo, 24'sd100);
    send_beat(pmpt_pkg::OP_LOAD, hi, hi, 24'sd100);
    send_beat(pmpt_pkg::OP_LOAD, lo, hi, 24'sd100);
    send_beat(pmpt_pkg::OP_LOAD, 24'sd5, 24'sd5, 24'sd5);
    send_beat(pmpt_pkg::OP_LOAD, 24'sd5, 24'sd5, 24'sd5);
    send_beat(pmpt_pkg::OP_LOAD, 24'sd9, 24'sd9, 24'sd9);
    send_beat(pmpt_pkg::OP_LOAD, 24'sd1, 24'sd2, lo);
    send_beat(pmpt_pkg::OP_QUERY, 24'sd1000, 24'sd10, 24'sd50);
    send_beat(pmpt_pkg::OP_QUERY, 24'sd1000, 24'sd10, 24'sd200);
    send_beat(pmpt_pkg::OP_QUERY, 24'sd10, 24'sd1000, 24'sd50);
    send_beat(pmpt_pkg::OP_QUERY, hi, hi, hi);
    send_beat(pmpt_pkg::OP_QUERY, lo, lo, lo);
    write_margin('0);
    send_beat(pmpt_pkg::OP_QUERY, 24'sd1000, 24'sd10, 24'sd50);
    write_margin({pmpt_pkg::MARGIN_W{1'b1}});
    send_beat(pmpt_pkg::OP_QUERY, 24'sd10, 24'sd1000, hi);
    send_beat(pmpt_pkg::OP_QUERY, -24'sd1000, 24'sd10, 24'sd50);
  endtask

  // Fill the store to capacity, drop two vertices, query, clear and query again.
  task automatic test_overflow();
    write_margin(pmpt_pkg::MARGIN_RESET);
    no_idle = 1'b1;
    send_beat(pmpt_pkg::OP_CLEAR, '0, '0, '0);
    for (int i = 0; i < pmpt_pkg::VERTEX_CAP + 2; i++)
      send_beat(pmpt_pkg::OP_LOAD, rand_coord(), rand_coord(), rand_coord());
    no_idle = 1'b0;
    send_beat(pmpt_pkg::OP_QUERY, 24'sd0, 24'sd0, 24'sd0);
    send_beat(pmpt_pkg::OP_CLEAR, '0, '0, '0);
    send_beat(pmpt_pkg::OP_QUERY, 24'sd0, 24'sd0, 24'sd0);
    drain();
  endtask

  // Long receiver hold-off while queries keep coming, then a full pause.
  task automatic test_backpressure();
    send_beat(pmpt_pkg::OP_CLEAR, '0, '0, '0);
    send_beat(pmpt_pkg::OP_LOAD, -24'sd100, -24'sd100, 24'sd0);
    send_beat(pmpt_pkg::OP_LOAD, 24'sd100, -24'sd100, 24'sd0);
    send_beat(pmpt_pkg::OP_LOAD, 24'sd0, 24'sd100, 24'sd0);
    drain();
    hold_left = 600;
    for (int i = 0; i < 6; i++)
      send_beat(pmpt_pkg::OP_QUERY, coord_t'($urandom_range(0, 40)) - coord_t'(20),
                24'sd0, 24'sd10);
    drain();
  endtask

  // Random meshes built from whole triangles, queries near them, and noise.
  task automatic test_random_meshes();
    int sent, tris, r;
    coord_t ax, ay, qx, qy;
    sent = 0;
    while (sent < 540) begin
      if ($urandom_range(0, 5) == 0) begin
        r = $urandom_range(0, 3);
        write_margin(r == 0 ? '0 : r == 1 ? {pmpt_pkg::MARGIN_W{1'b1}}
                                          : pmpt_pkg::MARGIN_W'($urandom));
      end
      no_idle = ($urandom_range(0, 4) == 0);
      send_beat(pmpt_pkg::OP_CLEAR, '0, '0, '0);
      sent++;
      tris = $urandom_range(1, 6);
      for (int t = 0; t < 3 * tris; t++) begin
        send_beat(pmpt_pkg::OP_LOAD, rand_coord(), rand_coord(), rand_coord());
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_beat(pmpt_pkg::OP_LOAD, rand_coord(), rand_coord(), rand_coord());
        sent++;
      end
      for (int q = 0; q < 4; q++) begin
        r = $urandom_range(0, 9);
        if (r < 6) begin
          // Aim near half of the x and y of stored first vertices so crossings are likely.
          ax = mesh_x[3 * $urandom_range(0, tris - 1)];
          ay = mesh_y[3 * $urandom_range(0, tris - 1)];
          qx = (ax >>> 1) + (rand_coord() >>> 2);
          qy = (ay >>> 1) + (rand_coord() >>> 2);
          send_beat(pmpt_pkg::OP_QUERY, qx, qy, rand_coord());
        end else if (r < 9) begin
          send_beat(pmpt_pkg::OP_QUERY, rand_coord(), rand_coord(), rand_coord());
        end else begin
          send_beat(pmpt_pkg::OP_NONE, rand_coord(), rand_coord(), rand_coord());
        end
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    mesh_len = 0;
    mesh_floor = pmpt_pkg::LOWEST_RESET;
    mesh_dropped = 1'b0;
    margin = pmpt_pkg::MARGIN_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_mesh();
    test_directed_mesh();
    test_backpressure();
    test_overflow();
    test_random_meshes();
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
